// ===== rtl/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// hed_pkg: shared types and constants of the HTML entity decoder
// Byte classes, entity-matching state and the step function that advances
// one entity match by one byte.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int NAME_COUNT = 5;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Entity names, first character in the top byte, padded with zero bytes.
  localparam logic [39:0] NAME_TEXT [NAME_COUNT] = '{
    {"lt;", 16'h0000},
    {"gt;", 16'h0000},
    "quot;",
    "apos;",
    {"amp;", 8'h00}
  };
  localparam logic [2:0] NAME_CHARS [NAME_COUNT] = '{3'd3, 3'd3, 3'd5, 3'd5, 3'd4};
  localparam logic [7:0] NAME_OUT [NAME_COUNT] = '{8'h3C, 8'h3E, 8'h22, 8'h27, 8'h26};

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_AMP,
    MODE_NAME,
    MODE_NUM
  } mode_t;

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_SIGN,
    PH_DIGIT,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    ACT_WAIT,
    ACT_LITERAL,
    ACT_DECODED
  } act_t;

  typedef struct packed {
    logic       is_amp;
    logic       is_semi;
    logic       is_hash;
    logic       is_digit;
    logic       is_blank;
    logic       is_sign;
    logic       is_minus;
    logic [3:0] digit;
    logic [7:0] folded;
  } class_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    class_t     cls;
  } item_t;

  typedef struct packed {
    mode_t                 mode;
    logic [NAME_COUNT-1:0] cands;
    logic [2:0]            plen;
    logic [7:0]            nval;
    logic                  nneg;
    phase_t                phase;
  } judge_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] val;
    judge_t     nxt;
  } judge_res_t;

  localparam judge_t JUDGE_IDLE  = '{MODE_IDLE, '0, 3'd0, 8'd0, 1'b0, PH_BLANK};
  localparam judge_t JUDGE_START = '{MODE_AMP, '1, 3'd0, 8'd0, 1'b0, PH_BLANK};

  function automatic class_t classify(input logic [7:0] b);
    class_t c;
    c.is_amp   = (b == CH_AMP);
    c.is_semi  = (b == CH_SEMI);
    c.is_hash  = (b == CH_HASH);
    c.is_digit = (b inside {[8'h30:8'h39]});
    c.is_blank = (b == CH_SPACE) || (b inside {[8'h09:8'h0D]});
    c.is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
    c.is_minus = (b == CH_MINUS);
    c.digit    = b[3:0];
    c.folded   = (b inside {[8'h41:8'h5A]}) ? b + 8'd32 : b;
    return c;
  endfunction

  function automatic logic [7:0] name_char(input int i, input logic [2:0] j);
    logic [7:0] ch;
    case (j)
      3'd0:    ch = NAME_TEXT[i][39:32];
      3'd1:    ch = NAME_TEXT[i][31:24];
      3'd2:    ch = NAME_TEXT[i][23:16];
      3'd3:    ch = NAME_TEXT[i][15:8];
      3'd4:    ch = NAME_TEXT[i][7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Advance an open entity by one byte. The caller handles the idle case,
  // the hold limit and the end of the string.
  function automatic judge_res_t judge_feed(input judge_t st, input class_t cl);
    judge_res_t            r;
    logic [NAME_COUNT-1:0] hit;
    logic [NAME_COUNT-1:0] full;
    logic [7:0]            dec_val;
    logic [2:0]            plen_inc;
    r.act    = ACT_WAIT;
    r.val    = 8'h00;
    r.nxt    = st;
    hit      = '0;
    full     = '0;
    dec_val  = 8'h00;
    plen_inc = (st.plen == 3'd7) ? 3'd7 : st.plen + 3'd1;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (st.cands[i] && (st.plen < NAME_CHARS[i]) && (cl.folded == name_char(i, st.plen))) begin
        hit[i] = 1'b1;
        if (st.plen == NAME_CHARS[i] - 3'd1) begin
          full[i] = 1'b1;
          dec_val = NAME_OUT[i];
        end
      end
    end
    case (st.mode)
      MODE_AMP, MODE_NAME: begin
        if (full != '0) begin
          r.act = ACT_DECODED;
          r.val = dec_val;
          r.nxt = JUDGE_IDLE;
        end else if (hit != '0) begin
          r.nxt.mode  = MODE_NAME;
          r.nxt.cands = hit;
          r.nxt.plen  = plen_inc;
        end else if ((st.mode == MODE_AMP) && cl.is_hash) begin
          r.nxt.mode  = MODE_NUM;
          r.nxt.cands = '0;
          r.nxt.plen  = plen_inc;
        end else begin
          r.act = ACT_LITERAL;
          r.nxt = JUDGE_IDLE;
        end
      end
      MODE_NUM: begin
        if (cl.is_semi) begin
          r.act = ACT_DECODED;
          r.val = st.nneg ? 8'd0 - st.nval : st.nval;
          r.nxt = JUDGE_IDLE;
        end else begin
          r.nxt.plen = plen_inc;
          case (st.phase)
            PH_BLANK: begin
              if (cl.is_blank) begin
                r.nxt.phase = PH_BLANK;
              end else if (cl.is_sign) begin
                r.nxt.nneg  = cl.is_minus;
                r.nxt.phase = PH_SIGN;
              end else if (cl.is_digit) begin
                r.nxt.nval  = {4'd0, cl.digit};
                r.nxt.phase = PH_DIGIT;
              end else begin
                r.nxt.phase = PH_STOP;
              end
            end
            PH_SIGN, PH_DIGIT: begin
              if (cl.is_digit) begin
                r.nxt.nval  = 8'(st.nval * 8'd10 + {4'd0, cl.digit});
                r.nxt.phase = PH_DIGIT;
              end else begin
                r.nxt.phase = PH_STOP;
              end
            end
            default: r.nxt.phase = PH_STOP;
          endcase
        end
      end
      default: begin
        r.act = ACT_LITERAL;
        r.nxt = JUDGE_IDLE;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/html_entity_decoder.sv =====
// ----------------------------------------------------------------------------
// html_entity_decoder: streaming HTML character entity decoder
// Decodes &lt; &gt; &quot; &apos; &amp; (any case) and decimal &#...;
// references in a byte stream; unmatched '&' passes through literally.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | word
//   ---------+----------------------+---------------------
//   in       | in_valid / in_ready  | in_byte, in_last
//   out      | out_valid / out_ready| out_byte, out_last
//
// A byte taken from the input queue is scanned as it is popped, so plain text
// moves at one word per cycle unless the output stalls. When an open entity
// proves literal, each byte held after its '&' is rescanned through a
// registered read of the hold buffer; a '&' left open at string end is
// emitted by a step of its own. Reset clears the queue, pointers and match
// state; the hold buffer needs no clearing. A stalled output stops the
// scanner while the two-word input queue keeps accepting until it is full.
module html_entity_decoder import hed_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  hed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  hed_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ===== rtl/hed_front.sv =====
// ----------------------------------------------------------------------------
// hed_front: input side of the HTML entity decoder
// Takes text words, classifies each byte and keeps them in a short queue
// for the scanner.
// ----------------------------------------------------------------------------
module hed_front import hed_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pull;

  assign in_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pull     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data: in_byte, last: in_last, cls: classify(in_byte)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pull) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pull) begin
        count <= count + 1'b1;
      end else if (pull && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hed_back.sv =====
// ----------------------------------------------------------------------------
// hed_back: entity scanner of the HTML entity decoder
// Matches entities byte by byte, holds the bytes of an open entity in a
// circular buffer and rescans them when the entity turns out to be literal.
// ----------------------------------------------------------------------------
module hed_back import hed_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  typedef enum logic {
    ST_SCAN,
    ST_FEED
  } state_t;

  typedef enum logic [1:0] {
    RES_EMIT,
    RES_HOLD,
    RES_LIT
  } res_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(HOLD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [7:0]    hold_mem [HOLD_DEPTH];
  logic [7:0]    rd_data;

  state_t        state, state_next;
  judge_t        jst, jst_next;
  logic [CW-1:0] ent_len, ent_len_next;
  logic [CW-1:0] rest_len, rest_len_next;
  logic [AW-1:0] head_addr, head_addr_next;
  logic [AW-1:0] scan_addr, scan_addr_next;
  logic [AW-1:0] tail_addr, tail_addr_next;
  logic          end_flag, end_flag_next;
  logic          out_valid_next;
  logic [7:0]    out_byte_next;
  logic          out_last_next;

  logic          can_emit;
  logic          from_queue;
  logic          rd_en;
  logic          do_proc;
  logic          end_now;
  logic [7:0]    proc_byte;
  class_t        proc_cls;
  logic [CW-1:0] rest_after;
  judge_res_t    jr;
  res_t          res;
  logic [7:0]    res_val;

  assign can_emit   = !out_valid || out_ready;
  assign from_queue = (state == ST_SCAN);
  assign proc_byte  = from_queue ? q_item.data : rd_data;
  assign proc_cls   = from_queue ? q_item.cls : classify(rd_data);
  assign rest_after = from_queue ? rest_len : rest_len - 1'b1;
  assign end_now    = from_queue ? q_item.last : end_flag;
  assign jr         = judge_feed(jst, proc_cls);

  // What the byte under the scan pointer does to the open entity, if any.
  always_comb begin
    res     = RES_HOLD;
    res_val = proc_byte;
    if (jst.mode == MODE_IDLE) begin
      res = proc_cls.is_amp ? RES_HOLD : RES_EMIT;
    end else begin
      case (jr.act)
        ACT_DECODED: begin
          res     = RES_EMIT;
          res_val = jr.val;
        end
        ACT_WAIT:    res = (ent_len >= CW'(HOLD_DEPTH - 1)) ? RES_LIT : RES_HOLD;
        default:     res = RES_LIT;
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    jst_next       = jst;
    ent_len_next   = ent_len;
    rest_len_next  = rest_len;
    head_addr_next = head_addr;
    scan_addr_next = scan_addr;
    tail_addr_next = tail_addr;
    end_flag_next  = end_flag;
    out_valid_next = out_valid && !out_ready;
    out_byte_next  = out_byte;
    out_last_next  = out_last;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    do_proc        = 1'b0;

    case (state)
      ST_SCAN: begin
        if (rest_len != '0) begin
          rd_en      = 1'b1;
          state_next = ST_FEED;
        end else if (end_flag) begin
          // The string ended with an entity still open: its '&' is literal.
          if (can_emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = CH_AMP;
            out_last_next  = (ent_len == CW'(1));
            head_addr_next = ptr_inc(head_addr);
            scan_addr_next = ptr_inc(head_addr);
            rest_len_next  = ent_len - 1'b1;
            ent_len_next   = '0;
            jst_next       = JUDGE_IDLE;
            if (ent_len == CW'(1)) begin
              end_flag_next = 1'b0;
            end
          end
        end else if (q_valid && can_emit) begin
          q_pop   = 1'b1;
          do_proc = 1'b1;
        end
      end
      ST_FEED: begin
        if (can_emit) begin
          do_proc    = 1'b1;
          state_next = ST_SCAN;
        end
      end
      default: state_next = ST_SCAN;
    endcase

    if (do_proc) begin
      if (from_queue) begin
        tail_addr_next = ptr_inc(tail_addr);
        end_flag_next  = q_item.last;
      end else begin
        rest_len_next = rest_len - 1'b1;
      end
      scan_addr_next = ptr_inc(scan_addr);
      case (res)
        RES_EMIT: begin
          out_valid_next = 1'b1;
          out_byte_next  = res_val;
          out_last_next  = end_now && (rest_after == '0);
          head_addr_next = ptr_inc(scan_addr);
          ent_len_next   = '0;
          jst_next       = JUDGE_IDLE;
          if (end_now && (rest_after == '0)) begin
            end_flag_next = 1'b0;
          end
        end
        RES_LIT: begin
          // Emit the '&' and rescan everything held after it.
          out_valid_next = 1'b1;
          out_byte_next  = CH_AMP;
          out_last_next  = 1'b0;
          head_addr_next = ptr_inc(head_addr);
          scan_addr_next = ptr_inc(head_addr);
          rest_len_next  = rest_after + ent_len;
          ent_len_next   = '0;
          jst_next       = JUDGE_IDLE;
        end
        default: begin
          ent_len_next = ent_len + 1'b1;
          jst_next     = (jst.mode == MODE_IDLE) ? JUDGE_START : jr.nxt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold_mem[tail_addr] <= q_item.data;
    end
    if (rd_en) begin
      rd_data <= hold_mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SCAN;
      jst       <= JUDGE_IDLE;
      ent_len   <= '0;
      rest_len  <= '0;
      head_addr <= '0;
      scan_addr <= '0;
      tail_addr <= '0;
      end_flag  <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      state     <= state_next;
      jst       <= jst_next;
      ent_len   <= ent_len_next;
      rest_len  <= rest_len_next;
      head_addr <= head_addr_next;
      scan_addr <= scan_addr_next;
      tail_addr <= tail_addr_next;
      end_flag  <= end_flag_next;
      out_valid <= out_valid_next;
      out_last  <= out_last_next;
    end
    out_byte <= out_byte_next;
  end

  a_open_entity_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (ent_len == '0) == (jst.mode == MODE_IDLE))
    else $error("held byte count disagrees with entity mode");

  a_buffer_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, ent_len} + {1'b0, rest_len}) <= (CW + 1)'(HOLD_DEPTH))
    else $error("hold buffer overrun");

  a_feed_has_byte: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FEED) |-> (rest_len != '0))
    else $error("rescan step without a byte to rescan");

  a_end_has_entity: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && end_flag && rest_len == '0) |-> (ent_len != '0))
    else $error("string end pending with nothing left to resolve");

  a_last_closes_string: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last && !out_ready) |=> !end_flag)
    else $error("string end still pending after its last word");

endmodule

// ===== verif/html_entity_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// html_entity_decoder_tb: self-checking bench for the HTML entity decoder
// Streams text through the decoder. A short scripted part covers the named
// entities in mixed case, decimal references and strings that end with an
// entity still open. A random part follows, made mostly of well-formed
// entities, with broken ones, long references and plain text mixed in. Every
// output word is compared with a behavioral decoder kept in this bench.
// ----------------------------------------------------------------------------
module html_entity_decoder_tb;
  import hed_pkg::*;

  localparam int HOLD_BYTES   = 32;
  localparam int ENT_COUNT    = 5;
  localparam int RAND_WORDS   = 340;
  localparam int LONG_HOLD    = 150;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  typedef struct {
    string text;
    bit    typed;
    string want;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  string      ent_text [ENT_COUNT] = '{"lt;", "gt;", "quot;", "apos;", "amp;"};
  logic [7:0] ent_char [ENT_COUNT] = '{"<", ">", "\"", "'", "&"};

  // Rows that end a string; typed rows carry their decoded text.
  script_row_t script_rows [11] = '{
    '{"\001\377", 1'b1, "\001\377"},
    '{"&Lt;",     1'b1, "<"},
    '{"&gT;",     1'b1, ">"},
    '{"&QUOT;",   1'b1, "\""},
    '{"&apos;",   1'b1, "'"},
    '{"&amP;",    1'b1, "&"},
    '{"&#-300;",  1'b0, ""},
    '{"&#;",      1'b0, ""},
    '{"&q",       1'b1, "&q"},
    '{"&",        1'b1, "&"},
    '{"&#12",     1'b1, "&#12"}
  };

  out_word_t  decoded_q [$];
  logic [7:0] held_text [$];
  out_word_t  head_word;
  int         mismatch_count = 0;
  int         burst_left = 0;
  bit         hold_off_req = 1'b0;

  html_entity_decoder #(.HOLD_DEPTH(HOLD_BYTES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always #2 clk = ~clk;

  initial begin
    #4000000;
    $display("** html_entity_decoder: FAILED **");
    $finish;
  end

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Resolve the text s[at..at+m-1], which starts with an ampersand.
  function automatic act_t judge_entity(input logic [7:0] s [$], input int at, input int m,
                                        input bit at_end, output logic [7:0] val,
                                        output int used);
    int         len;
    bit         ok;
    bit         pending;
    logic [7:0] c;
    logic [7:0] nval;
    bit         nneg;
    phase_t     ph;
    val     = 8'h00;
    used    = 1;
    pending = 1'b0;
    nval    = 8'h00;
    nneg    = 1'b0;
    ph      = PH_BLANK;
    if (m < 2) return at_end ? ACT_LITERAL : ACT_WAIT;
    for (int i = 0; i < ENT_COUNT; i++) begin
      len = ent_text[i].len();
      ok  = 1'b1;
      for (int j = 0; j < len && j + 1 < m; j++)
        if (fold_case(s[at+j+1]) != ent_text[i][j]) ok = 1'b0;
      if (ok && m - 1 >= len) begin
        val  = ent_char[i];
        used = len + 1;
        return ACT_DECODED;
      end
      if (ok) pending = 1'b1;
    end
    if (pending) return at_end ? ACT_LITERAL : ACT_WAIT;
    if (s[at+1] != CH_HASH) return ACT_LITERAL;
    for (int k = 2; k < m; k++) begin
      c = s[at+k];
      if (c == CH_SEMI) begin
        val  = nneg ? 8'd0 - nval : nval;
        used = k + 1;
        return ACT_DECODED;
      end
      case (ph)
        PH_BLANK: begin
          if (is_space(c)) begin
            ph = PH_BLANK;
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            nneg = (c == CH_MINUS);
            ph   = PH_SIGN;
          end else if (is_digit(c)) begin
            nval = c - CH_ZERO;
            ph   = PH_DIGIT;
          end else begin
            ph = PH_STOP;
          end
        end
        PH_SIGN, PH_DIGIT: begin
          if (is_digit(c)) begin
            nval = 8'(nval * 8'd10 + (c - CH_ZERO));
            ph   = PH_DIGIT;
          end else begin
            ph = PH_STOP;
          end
        end
        default: ph = PH_STOP;
      endcase
    end
    return at_end ? ACT_LITERAL : ACT_WAIT;
  endfunction

  // Feed one byte to the behavioral decoder. Its output is queued only when
  // keep is set; typed rows queue their own text instead.
  task automatic decode_byte(input logic [7:0] b, input bit at_end, input bit keep);
    logic [7:0] q [$];
    out_word_t  res [$];
    out_word_t  w;
    act_t       act;
    logic [7:0] v;
    int         u;
    int         pos;
    bit         waiting;
    q = held_text;
    q.insert(q.size(), b);
    pos     = 0;
    waiting = 1'b0;
    while (pos < q.size() && !waiting) begin
      w.last = 1'b0;
      if (q[pos] != CH_AMP) begin
        w.data = q[pos];
        res.insert(res.size(), w);
        pos++;
      end else begin
        act = judge_entity(q, pos, q.size() - pos, at_end, v, u);
        // A reference still open after a full hold buffer gives up its '&'.
        if (act == ACT_WAIT && q.size() - pos >= HOLD_BYTES) act = ACT_LITERAL;
        case (act)
          ACT_WAIT: waiting = 1'b1;
          ACT_DECODED: begin
            w.data = v;
            res.insert(res.size(), w);
            pos += u;
          end
          default: begin
            w.data = CH_AMP;
            res.insert(res.size(), w);
            pos++;
          end
        endcase
      end
    end
    if (waiting) held_text = q[pos:$];
    else held_text.delete();
    if (at_end && res.size() > 0) res[res.size()-1].last = 1'b1;
    if (keep) foreach (res[i]) decoded_q.insert(decoded_q.size(), res[i]);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [7:0] b, input bit l, input bit keep);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    decode_byte(b, l, keep);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] any_case(input logic [7:0] c);
    return (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) ? c - 8'd32 : c;
  endfunction

  // One random fragment of text, mostly well-formed entities.
  task automatic make_fragment(output logic [7:0] seg [$]);
    int    kind;
    int    e;
    int    cut;
    string name;
    seg.delete();
    kind = $urandom_range(0, 99);
    e    = $urandom_range(0, ENT_COUNT - 1);
    name = ent_text[e];
    if (kind < 25) begin
      repeat ($urandom_range(1, 4)) seg.insert(seg.size(), 8'($urandom_range(1, 255)));
    end else if (kind < 50) begin
      seg.insert(seg.size(), CH_AMP);
      for (int i = 0; i < name.len(); i++) seg.insert(seg.size(), any_case(name[i]));
    end else if (kind < 60) begin
      cut = $urandom_range(1, name.len() - 1);
      seg.insert(seg.size(), CH_AMP);
      for (int i = 0; i < cut; i++) seg.insert(seg.size(), any_case(name[i]));
      if ($urandom_range(0, 1) == 1) seg.insert(seg.size(), 8'($urandom_range(1, 255)));
    end else if (kind < 80) begin
      seg.insert(seg.size(), CH_AMP);
      seg.insert(seg.size(), CH_HASH);
      repeat ($urandom_range(0, 2))
        seg.insert(seg.size(), ($urandom_range(0, 1) == 1) ? CH_SPACE
                                                           : 8'($urandom_range(9, 13)));
      case ($urandom_range(0, 2))
        0: seg.insert(seg.size(), CH_PLUS);
        1: seg.insert(seg.size(), CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 5))
        seg.insert(seg.size(), 8'($urandom_range(CH_ZERO, CH_NINE)));
      if ($urandom_range(0, 9) == 0) seg.insert(seg.size(), 8'($urandom_range(1, 255)));
      if ($urandom_range(0, 9) != 0) seg.insert(seg.size(), CH_SEMI);
    end else if (kind < 90) begin
      // Long references straddle the point where the hold buffer gives up.
      seg.insert(seg.size(), CH_AMP);
      seg.insert(seg.size(), CH_HASH);
      repeat ($urandom_range(HOLD_BYTES - 6, HOLD_BYTES))
        seg.insert(seg.size(), ($urandom_range(0, 1) == 1) ? CH_SPACE
                                                           : 8'($urandom_range(CH_ZERO, CH_NINE)));
      seg.insert(seg.size(), CH_SEMI);
    end else begin
      seg.insert(seg.size(), CH_AMP);
      case ($urandom_range(0, 2))
        0: seg.insert(seg.size(), CH_AMP);
        1: seg.insert(seg.size(), CH_HASH);
        default: seg.insert(seg.size(), 8'($urandom_range(1, 255)));
      endcase
    end
  endtask

  // Output side: stall styles change now and then, plus one long hold-off.
  initial begin
    int  style;
    int  style_left;
    int  tick;
    bit  hold_off_done;
    style = 0;
    style_left = 0;
    tick = 0;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(20, 100);
        end
        style_left--;
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= (tick % 7 > 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: word not expected: out_byte %02h out_last %0b",
                 $time, out_byte, out_last);
        mismatch_count++;
      end else begin
        head_word = decoded_q.pop_front();
        if (out_byte !== head_word.data || out_last !== head_word.last) begin
          $display("%0t: out_byte expected %02h got %02h, out_last expected %0b got %0b",
                   $time, head_word.data, out_byte, head_word.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [7:0] seg [$];
    out_word_t  w;
    int         sent;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (script_rows[r]) begin
      if (script_rows[r].typed) begin
        for (int i = 0; i < script_rows[r].want.len(); i++) begin
          w.data = script_rows[r].want[i];
          w.last = (i == script_rows[r].want.len() - 1);
          decoded_q.insert(decoded_q.size(), w);
        end
      end
      for (int i = 0; i < script_rows[r].text.len(); i++)
        send_word(script_rows[r].text[i], i == script_rows[r].text.len() - 1,
                  !script_rows[r].typed);
    end

    sent = 0;
    while (sent < RAND_WORDS) begin
      make_fragment(seg);
      foreach (seg[i]) begin
        if (sent == RAND_WORDS / 3) hold_off_req = 1'b1;
        send_word(seg[i], $urandom_range(0, 19) == 0, 1'b1);
        sent++;
      end
    end
    // Close the string so nothing stays held.
    send_word("x", 1'b1, 1'b1);
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** html_entity_decoder: PASSED **");
    end else begin
      $display("** html_entity_decoder: FAILED **");
    end
    $finish;
  end

endmodule
